>>> hw/rtl/msce_pkg.sv
// Shared types, constants and case tables for the marching squares cell emitter.
package msce_pkg;

	localparam int unsigned MAX_RESOLUTION = 1024;
	localparam int unsigned RES_W          = 11;
	localparam int unsigned POS_W          = 12;
	localparam int unsigned OFS_W          = POS_W + 1;
	localparam int unsigned CNT_W          = 16;
	localparam int unsigned SAMPLE_W       = 16;
	localparam int unsigned CELL_W         = 10;
	localparam int unsigned CFG_ADDR_W     = 1;
	localparam int unsigned CFG_DATA_W     = 16;
	localparam int unsigned IN_DATA_W      = 88;
	localparam int unsigned OUT_DATA_W     = 40;

	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_GRID_RES  = 1'b1;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd32768;
	localparam logic [RES_W-1:0]    GRID_RES_RST  = 11'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_VERT,
		ST_TRI
	} state_t;

	typedef struct packed {
		logic                    valid;
		logic                    is_index;
		logic [2:0]              spot;
		logic [2:0]              entry;
		logic                    last;
		logic signed [OFS_W-1:0] ofs_x;
		logic signed [OFS_W-1:0] ofs_y;
		logic [CNT_W-1:0]        base;
	} op_t;

	localparam logic [7:0] CASE_SPOTS [16] = '{
		8'h00, 8'h0B, 8'h16, 8'h1D, 8'h68, 8'h63, 8'h7E, 8'h75,
		8'hD0, 8'hDB, 8'hC6, 8'hCD, 8'hB8, 8'hB3, 8'hAE, 8'hA5
	};

	localparam logic [1:0] SPOT_DX [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
	localparam logic [1:0] SPOT_DY [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};

	localparam logic [3:0] TRI_COUNT [16] = '{
		4'd0, 4'd3, 4'd3, 4'd6, 4'd3, 4'd6, 4'd6, 4'd9,
		4'd3, 4'd6, 4'd6, 4'd9, 4'd6, 4'd9, 4'd9, 4'd6
	};

	localparam logic [2:0] TRI_ENTRY [16][9] = '{
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd3, 3'd1, 3'd2, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd3, 3'd4, 3'd0, 3'd4, 3'd2, 3'd0, 3'd2, 3'd1},
		'{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd0, 3'd2, 3'd1, 3'd2, 3'd3, 3'd1, 3'd3, 3'd4},
		'{3'd0, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0},
		'{3'd3, 3'd4, 3'd2, 3'd3, 3'd2, 3'd1, 3'd3, 3'd1, 3'd0},
		'{3'd4, 3'd1, 3'd0, 3'd4, 3'd0, 3'd2, 3'd4, 3'd2, 3'd3},
		'{3'd0, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0}
	};

endpackage

>>> hw/rtl/msce_seq.sv
// Sequencer: classifies the cell and steps through its vertex spots and triangle indices.
module msce_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [msce_pkg::SAMPLE_W-1:0]   sample_a,
	input  logic [msce_pkg::SAMPLE_W-1:0]   sample_b,
	input  logic [msce_pkg::SAMPLE_W-1:0]   sample_c,
	input  logic [msce_pkg::SAMPLE_W-1:0]   sample_d,
	input  logic [msce_pkg::CELL_W-1:0]     cell_x,
	input  logic [msce_pkg::CELL_W-1:0]     cell_y,
	input  logic                            new_mesh,
	input  logic [msce_pkg::SAMPLE_W-1:0]   threshold,
	input  logic [msce_pkg::RES_W-1:0]      grid_resolution,
	input  logic                            take,
	output msce_pkg::op_t                   op
);
	import msce_pkg::*;

	state_t                  state_q, state_d;
	logic [3:0]              cs_q;
	logic [7:0]              mask_q;
	logic [3:0]              tri_idx_q;
	logic [CNT_W-1:0]        base_q;
	logic [CNT_W-1:0]        vcount_q;
	logic signed [OFS_W-1:0] ofs_x_q, ofs_y_q;

	logic [3:0]              cs;
	logic [CNT_W-1:0]        cnt_start;
	logic [RES_W-1:0]        res_eff;
	logic [2:0]              low_spot;
	logic                    tri_last;
	logic                    accept;

	always_comb begin
		cs = {sample_d >= threshold, sample_c >= threshold,
			sample_b >= threshold, sample_a >= threshold};
		cnt_start = new_mesh ? '0 : vcount_q;
		res_eff = (grid_resolution > RES_W'(MAX_RESOLUTION)) ?
			RES_W'(MAX_RESOLUTION) : grid_resolution;
		low_spot = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (mask_q[i]) low_spot = 3'(i);
		end
		tri_last = (tri_idx_q == TRI_COUNT[cs_q] - 4'd1);
		accept = in_valid && (state_q == ST_IDLE);
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		op       = '0;
		op.ofs_x = ofs_x_q;
		op.ofs_y = ofs_y_q;
		op.base  = base_q;
		op.spot  = low_spot;
		op.entry = TRI_ENTRY[cs_q][tri_idx_q];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && CASE_SPOTS[cs] != 8'h00) state_d = ST_VERT;
			end
			ST_VERT: begin
				op.valid = 1'b1;
				if (take && (mask_q & (mask_q - 8'd1)) == 8'h00) state_d = ST_TRI;
			end
			ST_TRI: begin
				op.valid    = 1'b1;
				op.is_index = 1'b1;
				op.last     = tri_last;
				if (take && tri_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vcount_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				vcount_q <= cnt_start;
			end else if (state_q == ST_VERT && take) begin
				vcount_q <= vcount_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cs_q      <= cs;
			mask_q    <= CASE_SPOTS[cs];
			tri_idx_q <= '0;
			base_q    <= cnt_start;
			ofs_x_q   <= $signed({2'b00, cell_x, 1'b0}) - $signed({2'b00, res_eff});
			ofs_y_q   <= $signed({2'b00, cell_y, 1'b0}) - $signed({2'b00, res_eff});
		end else if (take) begin
			if (state_q == ST_VERT) mask_q <= mask_q & (mask_q - 8'd1);
			if (state_q == ST_TRI) tri_idx_q <= tri_idx_q + 4'd1;
		end
	end

endmodule

>>> hw/rtl/msce_unit.sv
// Shared add and saturate unit with the result register of the master side.
module msce_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  msce_pkg::op_t                   op,
	output logic                            take,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            is_index,
	output logic [msce_pkg::POS_W-1:0]      pos_x,
	output logic [msce_pkg::POS_W-1:0]      pos_y,
	output logic [msce_pkg::CNT_W-1:0]      vertex_index,
	output logic                            last
);
	import msce_pkg::*;

	logic                    valid_q;
	logic                    is_index_q, last_q;
	logic [POS_W-1:0]        pos_x_q, pos_y_q;
	logic [CNT_W-1:0]        vidx_q;

	logic [CNT_W-1:0]        add_a, add_b, add_sum;
	logic signed [OFS_W-1:0] sum_y;
	logic [POS_W-1:0]        sat_x, sat_y;

	function automatic logic [POS_W-1:0] sat_pos(input logic [OFS_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v[OFS_W-1] != v[OFS_W-2]) begin
			r = v[OFS_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		if (op.is_index) begin
			add_a = op.base;
			add_b = CNT_W'(op.entry);
		end else begin
			add_a = CNT_W'($signed(op.ofs_x));
			add_b = CNT_W'(SPOT_DX[op.spot]);
		end
		add_sum = add_a + add_b;
		sum_y   = op.ofs_y + $signed({{(OFS_W-2){1'b0}}, SPOT_DY[op.spot]});
		sat_x   = sat_pos(add_sum[OFS_W-1:0]);
		sat_y   = sat_pos(sum_y);
		take    = op.valid && (!valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			is_index_q <= op.is_index;
			last_q     <= op.last;
			pos_x_q    <= op.is_index ? '0 : sat_x;
			pos_y_q    <= op.is_index ? '0 : sat_y;
			vidx_q     <= op.is_index ? add_sum : '0;
		end
	end

	assign out_valid    = valid_q;
	assign is_index     = is_index_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign vertex_index = vidx_q;
	assign last         = last_q;

endmodule

>>> hw/rtl/marching_squares_cell_emitter.sv
// Top level of the marching squares cell emitter: stream ports, registers, core.
// An accepted cell is registered in the sequencer, then the add unit's result
// register raises m_tvalid. A cell gives 0 to 14 results, issued one per cycle
// to the shared add unit unless the output stalls; new cells are held off.
// Reset: threshold 32768, grid_resolution 64, vertex count 0, no beat pending.
module marching_squares_cell_emitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sample_a, sample_b, sample_c, sample_d, cell_x, cell_y, zero pad
	input  logic [msce_pkg::IN_DATA_W-1:0]    s_tdata,
	// new_mesh
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pos_x, pos_y, vertex_index
	output logic [msce_pkg::OUT_DATA_W-1:0]   m_tdata,
	// is_index
	output logic                              m_tuser,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [msce_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [msce_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import msce_pkg::*;

	logic [SAMPLE_W-1:0] threshold_q;
	logic [RES_W-1:0]    grid_res_q;
	op_t                 op;
	logic                take;
	logic [POS_W-1:0]    pos_x, pos_y;
	logic [CNT_W-1:0]    vertex_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			grid_res_q  <= GRID_RES_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_GRID_RES:  grid_res_q  <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	msce_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.sample_a        (s_tdata[15:0]),
		.sample_b        (s_tdata[31:16]),
		.sample_c        (s_tdata[47:32]),
		.sample_d        (s_tdata[63:48]),
		.cell_x          (s_tdata[73:64]),
		.cell_y          (s_tdata[83:74]),
		.new_mesh        (s_tuser),
		.threshold       (threshold_q),
		.grid_resolution (grid_res_q),
		.take            (take),
		.op              (op)
	);

	msce_unit u_unit (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.take         (take),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.is_index     (m_tuser),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.vertex_index (vertex_index),
		.last         (m_tlast)
	);

	assign m_tdata = {vertex_index, pos_y, pos_x};

	a_vert_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[39:24] == 16'd0)
		else $error("vertex beat carries an index");

	a_index_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[23:0] == 24'd0)
		else $error("index beat carries a position");

	a_last_on_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("cell ends on a vertex beat");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		op.valid |-> !s_tready)
		else $error("cell accepted while results pending");

endmodule

>>> verif/marching_squares_cell_emitter_tb.sv
// Stream-level testbench for the marching squares cell emitter, checked against a local mesh predictor.
module marching_squares_cell_emitter_tb;

	localparam int CLK_HALF     = 10;
	localparam int RUN_LIMIT    = 50000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_RES      = 1024;
	localparam int BURST_CELLS  = 12;
	localparam int PRINT_CAP    = 50;

	localparam logic [3:0] CASE_NONE = 4'b0000;
	localparam logic [3:0] CASE_BC   = 4'b0110;
	localparam logic [3:0] CASE_AD   = 4'b1001;
	localparam logic [3:0] CASE_ALL  = 4'b1111;

	localparam logic [7:0] SPOT_MASK [16] = '{
		8'h00, 8'h0B, 8'h16, 8'h1D, 8'h68, 8'h63, 8'h7E, 8'h75,
		8'hD0, 8'hDB, 8'hC6, 8'hCD, 8'hB8, 8'hB3, 8'hAE, 8'hA5
	};
	localparam int SPOT_X [8] = '{0, 1, 2, 0, 2, 0, 1, 2};
	localparam int SPOT_Y [8] = '{0, 0, 0, 1, 1, 2, 2, 2};
	localparam int TRI_N [16] = '{0, 3, 3, 6, 3, 6, 6, 9, 3, 6, 6, 9, 6, 9, 9, 6};
	localparam int TRI_IDX [16][9] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 2, 1, 0, 0, 0, 0, 0, 0},
		'{0, 2, 1, 0, 0, 0, 0, 0, 0},
		'{0, 2, 1, 1, 2, 3, 0, 0, 0},
		'{0, 1, 2, 0, 0, 0, 0, 0, 0},
		'{0, 2, 1, 1, 2, 3, 0, 0, 0},
		'{0, 3, 1, 2, 4, 5, 0, 0, 0},
		'{0, 3, 4, 0, 4, 2, 0, 2, 1},
		'{0, 1, 2, 0, 0, 0, 0, 0, 0},
		'{0, 2, 1, 3, 4, 5, 0, 0, 0},
		'{0, 2, 1, 1, 2, 3, 0, 0, 0},
		'{1, 0, 2, 1, 2, 3, 1, 3, 4},
		'{0, 2, 1, 1, 2, 3, 0, 0, 0},
		'{3, 4, 2, 3, 2, 1, 3, 1, 0},
		'{4, 1, 0, 4, 0, 2, 4, 2, 3},
		'{0, 2, 1, 1, 2, 3, 0, 0, 0}
	};

	typedef struct packed {
		logic                                     new_mesh;
		logic [msce_pkg::CELL_W-1:0]              cell_y;
		logic [msce_pkg::CELL_W-1:0]              cell_x;
		logic [3:0][msce_pkg::SAMPLE_W-1:0]       smp;
	} cell_t;

	typedef struct packed {
		logic                         is_index;
		logic [msce_pkg::POS_W-1:0]   pos_x;
		logic [msce_pkg::POS_W-1:0]   pos_y;
		logic [msce_pkg::CNT_W-1:0]   vidx;
		logic                         last;
	} mesh_beat_t;

	logic                                clk      = 1'b0;
	logic                                arst_n   = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	// sample_a, sample_b, sample_c, sample_d, cell_x, cell_y, zero pad
	logic [msce_pkg::IN_DATA_W-1:0]      s_tdata  = '0;
	// new_mesh
	logic                                s_tuser  = 1'b0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	// pos_x, pos_y, vertex_index
	logic [msce_pkg::OUT_DATA_W-1:0]     m_tdata;
	// is_index
	logic                                m_tuser;
	logic                                m_tlast;
	logic                                cfg_we   = 1'b0;
	logic [msce_pkg::CFG_ADDR_W-1:0]     cfg_addr = '0;
	logic [msce_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

	logic [15:0]  iso_level = 16'd32768;
	logic [10:0]  grid_res  = 11'd64;
	logic [15:0]  vtx_count = '0;

	cell_t        cell_fifo [$];
	mesh_beat_t   mesh_fifo [$];
	cell_t        cur_cell;
	mesh_beat_t   next_beat;
	logic         in_next;
	bit           in_taken     = 1'b0;
	bit           out_taken    = 1'b0;
	bit           steady       = 1'b0;
	bit           hold_off_req = 1'b0;
	int           in_gap       = 0;
	int           out_gap      = 0;
	int           hold_left    = 0;
	int           in_beats     = 0;
	int           out_beats    = 0;
	int           err_cnt      = 0;

	marching_squares_cell_emitter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("marching_squares_cell_emitter test failed");
		$finish;
	end

	task automatic report_mismatch(string msg);
		if (err_cnt < PRINT_CAP)
			$display("mismatch at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic void add_cell(cell_t c);
		cell_fifo.insert(cell_fifo.size(), c);
	endfunction

	function automatic void add_beat(mesh_beat_t b);
		mesh_fifo.insert(mesh_fifo.size(), b);
	endfunction

	function automatic logic [11:0] clamp12(int v);
		if (v > 2047) v = 2047;
		if (v < -2048) v = -2048;
		return v[11:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Work out every beat a cell produces and advance the running vertex count, restarting it on a new mesh.
	function automatic void expand_cell(cell_t c);
		logic [3:0]  cs;
		logic [7:0]  mask;
		logic [15:0] base;
		int          res;
		int          k;
		int          n;
		mesh_beat_t  b;
		if (c.new_mesh) vtx_count = '0;
		res = (int'(grid_res) > MAX_RES) ? MAX_RES : int'(grid_res);
		for (k = 0; k < 4; k++) cs[k] = (c.smp[k] >= iso_level);
		mask = SPOT_MASK[cs];
		base = vtx_count;
		n = 0;
		for (k = 0; k < 8; k++) begin
			if (mask[k]) begin
				b.is_index = 1'b0;
				b.pos_x    = clamp12(2 * int'(c.cell_x) + SPOT_X[k] - res);
				b.pos_y    = clamp12(2 * int'(c.cell_y) + SPOT_Y[k] - res);
				b.vidx     = '0;
				b.last     = 1'b0;
				add_beat(b);
				vtx_count = vtx_count + 16'd1;
				n++;
			end
		end
		for (k = 0; k < TRI_N[cs]; k++) begin
			b.is_index = 1'b1;
			b.pos_x    = '0;
			b.pos_y    = '0;
			b.vidx     = base + 16'(TRI_IDX[cs][k]);
			b.last     = 1'b0;
			add_beat(b);
			n++;
		end
		if (n > 0) mesh_fifo[mesh_fifo.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [15:0] rand_sample();
		int t;
		case ($urandom_range(0, 9))
			0, 1, 2: t = $urandom_range(0, 65535);
			3, 4, 5: t = int'(iso_level) + int'($urandom_range(0, 8)) - 4;
			6, 7:    t = $urandom_range(0, 1) ? 65535 : 0;
			default: t = int'(iso_level) - int'($urandom_range(0, 1));
		endcase
		if (t < 0) t = 0;
		if (t > 65535) t = 65535;
		return t[15:0];
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		int    lim;
		int    k;
		lim = ((int'(grid_res) > MAX_RES) ? MAX_RES : int'(grid_res)) - 2;
		if (lim < 0 || $urandom_range(0, 7) == 0) lim = 1023;
		for (k = 0; k < 4; k++) c.smp[k] = rand_sample();
		c.cell_x   = 10'($urandom_range(0, lim));
		c.cell_y   = 10'($urandom_range(0, lim));
		c.new_mesh = ($urandom_range(0, 9) == 0);
		return c;
	endfunction

	// Inside corners get full scale or the exact iso level, outside ones zero or one below it.
	function automatic cell_t make_case_cell(logic [3:0] cs, bit extreme, int x, int y, bit nm);
		cell_t c;
		int    k;
		for (k = 0; k < 4; k++) begin
			if (cs[k]) c.smp[k] = extreme ? 16'hFFFF : iso_level;
			else c.smp[k] = extreme ? 16'h0000 : iso_level - 16'd1;
		end
		c.cell_x   = 10'(x);
		c.cell_y   = 10'(y);
		c.new_mesh = nm;
		return c;
	endfunction

	task automatic queue_random(int n);
		repeat (n) add_cell(rand_cell());
	endtask

	task automatic set_reg(logic [msce_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_addr = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == msce_pkg::REG_THRESHOLD) iso_level = val;
		else grid_res = val[10:0];
	endtask

	// Wait for the stream to empty, giving up once nothing has moved for a long time.
	task automatic settle();
		int idle_cycles;
		int seen;
		idle_cycles = 0;
		seen = in_beats + out_beats;
		while ((cell_fifo.size() != 0 || s_tvalid || mesh_fifo.size() != 0)
				&& idle_cycles < STALL_LIMIT) begin
			@(negedge clk);
			if (in_beats + out_beats != seen) begin
				seen = in_beats + out_beats;
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		if (idle_cycles >= STALL_LIMIT) begin
			report_mismatch($sformatf("stream stuck: %0d cells unsent, %0d beats missing",
				cell_fifo.size(), mesh_fifo.size()));
			cell_fifo.delete();
			mesh_fifo.delete();
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expand_cell(cur_cell);
			in_taken = 1'b1;
			in_beats++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			out_taken = 1'b1;
			out_beats++;
			if (mesh_fifo.size() == 0) begin
				report_mismatch($sformatf("unexpected beat data %h user %b last %b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				next_beat = mesh_fifo.pop_front();
				check_field("is_index", 16'(m_tuser), 16'(next_beat.is_index));
				check_field("pos_x", 16'(m_tdata[11:0]), 16'(next_beat.pos_x));
				check_field("pos_y", 16'(m_tdata[23:12]), 16'(next_beat.pos_y));
				check_field("vertex_index", m_tdata[39:24], next_beat.vidx);
				check_field("last", 16'(m_tlast), 16'(next_beat.last));
			end
		end
	end

	// Offer cells from the queue with random gaps between them, or none in steady mode.
	always @(negedge clk) begin
		if (arst_n) begin
			in_next = s_tvalid;
			if (in_taken) begin
				in_taken = 1'b0;
				in_next = 1'b0;
			end
			if (!in_next) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (cell_fifo.size() > 0) begin
					cur_cell = cell_fifo.pop_front();
					s_tdata <= {4'h0, cur_cell.cell_y, cur_cell.cell_x, cur_cell.smp};
					s_tuser <= cur_cell.new_mesh;
					in_next = 1'b1;
					in_gap = steady ? 0 : pick_gap();
				end
			end
			s_tvalid <= in_next;
		end
	end

	// Drop ready for random stretches outside steady mode, and for one long hold when asked.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (out_taken) begin
				out_taken = 1'b0;
				if (!steady) out_gap = pick_gap();
			end else if (!steady && out_gap == 0 && $urandom_range(0, 15) == 0) begin
				out_gap = pick_gap();
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int k;
		int cx;
		int cy;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < 16; k++) begin
			case (k % 4)
				0: begin cx = 0;    cy = 1023; end
				1: begin cx = 1023; cy = 0;    end
				2: begin cx = 62;   cy = 31;   end
				default: begin cx = 31; cy = 62; end
			endcase
			add_cell(make_case_cell(k[3:0], (k / 2) % 2 == 1, cx, cy,
				k == 0 || k == 9));
		end
		add_cell(make_case_cell(CASE_NONE, 1'b1, 5, 5, 1'b1));
		add_cell(make_case_cell(CASE_ALL, 1'b1, 0, 0, 1'b0));
		settle();

		hold_off_req = 1'b1;
		queue_random(70);
		settle();

		set_reg(msce_pkg::REG_THRESHOLD, 16'h0000);
		set_reg(msce_pkg::REG_GRID_RES, 16'd2);
		queue_random(60);
		settle();

		steady = 1'b1;
		set_reg(msce_pkg::REG_THRESHOLD, 16'hFFFF);
		set_reg(msce_pkg::REG_GRID_RES, 16'd1024);
		queue_random(60);
		settle();
		steady = 1'b0;

		set_reg(msce_pkg::REG_THRESHOLD, 16'($urandom_range(1, 65534)));
		set_reg(msce_pkg::REG_GRID_RES, 16'd0);
		add_cell(make_case_cell(CASE_ALL, 1'b1, 1023, 1023, 1'b0));
		queue_random(30);
		settle();

		set_reg(msce_pkg::REG_GRID_RES, {5'($urandom_range(1, 31)), 11'h7FF});
		queue_random(30);
		settle();

		// Send six-vertex cells back to back.
		steady = 1'b1;
		set_reg(msce_pkg::REG_THRESHOLD, 16'd32768);
		set_reg(msce_pkg::REG_GRID_RES, 16'd64);
		add_cell(make_case_cell(CASE_BC, 1'b1, 0, 0, 1'b1));
		repeat (BURST_CELLS)
			add_cell(make_case_cell($urandom_range(0, 1) ? CASE_BC : CASE_AD,
				bit'($urandom_range(0, 1)), $urandom_range(0, 62), $urandom_range(0, 62),
				1'b0));
		settle();
		steady = 1'b0;

		set_reg(msce_pkg::REG_THRESHOLD, 16'($urandom_range(0, 65535)));
		set_reg(msce_pkg::REG_GRID_RES, 16'($urandom_range(2, 1024)));
		queue_random(50);
		settle();

		if (err_cnt == 0)
			$display("marching_squares_cell_emitter test passed");
		else
			$display("marching_squares_cell_emitter test failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/msce_pkg.sv
hw/rtl/msce_seq.sv
hw/rtl/msce_unit.sv
hw/rtl/marching_squares_cell_emitter.sv
verif/marching_squares_cell_emitter_tb.sv
